### sv/rvmd_pkg.sv
package rvmd_pkg;

  localparam int XLEN       = 32;
  localparam int DIV_STEPS  = 4;                 // quotient bits resolved per stage
  localparam int DIV_STAGES = XLEN / DIV_STEPS;
  localparam int MUL_LAT    = 3;                 // multiplier register stages
  localparam int MUL_DLY    = DIV_STAGES - MUL_LAT;

  typedef logic [XLEN-1:0] word_t;

  typedef enum logic [2:0] {
    FN_MUL    = 3'd0,
    FN_MULH   = 3'd1,
    FN_MULHSU = 3'd2,
    FN_MULHU  = 3'd3,
    FN_DIV    = 3'd4,
    FN_DIVU   = 3'd5,
    FN_REM    = 3'd6,
    FN_REMU   = 3'd7
  } func_t;

  typedef struct packed {
    logic  valid;
    func_t func;
    logic  div_zero;
    logic  neg_q;
    logic  neg_r;
    word_t rem;
    word_t quo;
    word_t dvs;
  } div_slot_t;

endpackage

### sv/rvmd_if.sv
interface rvmd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface rvmd_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

### sv/rvmd_div_stage.sv
module rvmd_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  rvmd_pkg::div_slot_t slot_i,
  output rvmd_pkg::div_slot_t slot_o
);
  import rvmd_pkg::*;

  div_slot_t slot_r, slot_nxt;

  // restoring division, DIV_STEPS quotient bits per stage
  always_comb begin
    logic [XLEN:0]   sh;
    logic [XLEN:0]   trial;
    logic [XLEN-1:0] rem_w;
    logic [XLEN-1:0] quo_w;
    rem_w = slot_i.rem;
    quo_w = slot_i.quo;
    sh    = '0;
    trial = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      sh    = {rem_w, quo_w[XLEN-1]};
      trial = sh - {1'b0, slot_i.dvs};
      quo_w = {quo_w[XLEN-2:0], ~trial[XLEN]};
      if (!trial[XLEN]) begin
        rem_w = trial[XLEN-1:0];
      end else begin
        rem_w = sh[XLEN-1:0];
      end
    end
    slot_nxt     = slot_i;
    slot_nxt.rem = rem_w;
    slot_nxt.quo = quo_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else if (en) begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_o = slot_r;

endmodule

### sv/rvmd_mul.sv
module rvmd_mul (
  input  logic            clk,
  input  logic            en,
  input  rvmd_pkg::func_t func,
  input  rvmd_pkg::word_t a,
  input  rvmd_pkg::word_t b,
  output rvmd_pkg::word_t result
);
  import rvmd_pkg::*;

  localparam int H = XLEN / 2;

  // stage 1: partial products
  logic [XLEN-1:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  word_t           a1_r, b1_r;
  logic            hi1_r, sa1_r, sb1_r;
  // stage 2: unsigned 64-bit product
  logic [2*XLEN-1:0] sum_r;
  word_t             a2_r, b2_r;
  logic              hi2_r, sa2_r, sb2_r;
  // stage 3: signed correction and word select
  word_t             res_r;
  logic [2*XLEN-1:0] sum_nxt;
  word_t             res_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= a[H-1:0]    * b[H-1:0];
      pp_lh_r <= a[H-1:0]    * b[XLEN-1:H];
      pp_hl_r <= a[XLEN-1:H] * b[H-1:0];
      pp_hh_r <= a[XLEN-1:H] * b[XLEN-1:H];
      a1_r    <= a;
      b1_r    <= b;
      hi1_r   <= (func != FN_MUL);
      sa1_r   <= a[XLEN-1] & ((func == FN_MULH) || (func == FN_MULHSU));
      sb1_r   <= b[XLEN-1] & (func == FN_MULH);
    end
  end

  always_comb begin
    sum_nxt = {{XLEN{1'b0}}, pp_ll_r}
            + ({{H{1'b0}}, pp_lh_r, {H{1'b0}}})
            + ({{H{1'b0}}, pp_hl_r, {H{1'b0}}})
            + ({pp_hh_r, {XLEN{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      hi2_r <= hi1_r;
      sa2_r <= sa1_r;
      sb2_r <= sb1_r;
    end
  end

  always_comb begin
    if (hi2_r) begin
      res_nxt = sum_r[2*XLEN-1:XLEN] - (sa2_r ? b2_r : '0) - (sb2_r ? a2_r : '0);
    end else begin
      res_nxt = sum_r[XLEN-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

### sv/rv32m_multiply_divide_unit.sv
// path: the input stage loads on the accepting edge, then 8 divider stages and the
//   output register carry the request to result valid; the path is the same for every
//   function code
// throughput: one request per cycle; the whole pipeline holds while a result stalls
// reset: synchronous active-low rst_n clears every stage valid bit, data is not reset
module rv32m_multiply_divide_unit (
  input  logic       clk,
  input  logic       rst_n,
  rvmd_req_if.sink   in_req,
  rvmd_res_if.source out_res
);
  import rvmd_pkg::*;

  // global advance: the pipe moves unless a finished result is being held
  logic en;

  // input stage
  div_slot_t s0_r, s0_nxt;
  word_t     a_raw_r, b_raw_r;
  func_t     fn_in;
  logic      sgn_div;

  // divider chain, index 0 is the input stage
  div_slot_t chain [0:DIV_STAGES];

  // multiplier result and its alignment delay
  word_t mul_res;
  word_t mul_dly_r [0:MUL_DLY-1];

  // output register
  logic  out_valid_r, out_valid_nxt;
  word_t out_result_r, out_result_nxt;
  div_slot_t last;
  word_t     quo_fix, rem_fix;

  assign en           = !out_valid_r || out_res.ready;
  assign in_req.ready = en;

  assign fn_in   = func_t'(in_req.func);
  // signed divide and remainder both have func bit 0 clear
  assign sgn_div = !in_req.func[0];

  always_comb begin
    s0_nxt          = '0;
    s0_nxt.valid    = in_req.valid;
    s0_nxt.func     = fn_in;
    s0_nxt.div_zero = (in_req.operand_b == '0);
    s0_nxt.neg_q    = sgn_div & (in_req.operand_a[XLEN-1] ^ in_req.operand_b[XLEN-1]);
    s0_nxt.neg_r    = sgn_div & in_req.operand_a[XLEN-1];
    s0_nxt.rem      = '0;
    // magnitudes for the divider; min int / -1 falls out of the magnitude path
    s0_nxt.quo = (sgn_div && in_req.operand_a[XLEN-1]) ? (word_t'(0) - in_req.operand_a)
                                                       : in_req.operand_a;
    s0_nxt.dvs = (sgn_div && in_req.operand_b[XLEN-1]) ? (word_t'(0) - in_req.operand_b)
                                                       : in_req.operand_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (en) begin
      s0_r <= s0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_raw_r <= in_req.operand_a;
      b_raw_r <= in_req.operand_b;
    end
  end

  assign chain[0] = s0_r;

  genvar g;
  generate
    for (g = 0; g < DIV_STAGES; g++) begin : g_div
      rvmd_div_stage u_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .slot_i (chain[g]),
        .slot_o (chain[g+1])
      );
    end
  endgenerate

  // multiplier runs alongside the first divider stages
  rvmd_mul u_mul (
    .clk    (clk),
    .en     (en),
    .func   (s0_r.func),
    .a      (a_raw_r),
    .b      (b_raw_r),
    .result (mul_res)
  );

  // line the product up with the end of the divider chain
  always_ff @(posedge clk) begin
    if (en) begin
      mul_dly_r[0] <= mul_res;
      for (int i = 1; i < MUL_DLY; i++) begin
        mul_dly_r[i] <= mul_dly_r[i-1];
      end
    end
  end

  assign last = chain[DIV_STAGES];

  // sign fix-up; divide by zero yields all ones, remainder keeps the dividend
  assign quo_fix = last.div_zero ? '1 :
                   (last.neg_q ? (word_t'(0) - last.quo) : last.quo);
  assign rem_fix = last.neg_r ? (word_t'(0) - last.rem) : last.rem;

  always_comb begin
    out_valid_nxt = last.valid;
    case (last.func) inside
      FN_MUL, FN_MULH, FN_MULHSU, FN_MULHU: out_result_nxt = mul_dly_r[MUL_DLY-1];
      FN_DIV, FN_DIVU:                      out_result_nxt = quo_fix;
      default:                              out_result_nxt = rem_fix;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign out_res.valid  = out_valid_r;
  assign out_res.result = out_result_r;

endmodule

### sv/rvmd_checker.sv
module rvmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result
);

  // held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed");

  // input side is stopped exactly when a result is held back
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("request ready does not follow output stall");

  // nothing comes out straight after reset
  a_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // with no result and no request, a result next cycle needs in_ready high in the current one
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !in_valid |=> !out_valid || $past(in_ready))
    else $error("result appeared from nowhere");

endmodule

bind rv32m_multiply_divide_unit rvmd_checker u_rvmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_result (out_res.result)
);
